/* rtl/pixel_color_filter_top_defines.svh */
// Assertion macros shared by the RTL files.
// PCF_ASSERT checks a property on the rising clock edge, held off while reset is asserted.
// PCF_ASSERT_ALWAYS checks a property on every rising clock edge, reset included.
`ifndef PIXEL_COLOR_FILTER_TOP_DEFINES_SVH
`define PIXEL_COLOR_FILTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define PCF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pixel_color_filter assertion failed");

`define PCF_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("pixel_color_filter assertion failed");

`else

`define PCF_ASSERT(lbl, prop)

`define PCF_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

/* rtl/pcf_pkg.sv */
package pcf_pkg;

    localparam int CHAN_W = 8;

    typedef logic [CHAN_W-1:0] chan_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } pixel_t;

    typedef struct packed {
        pixel_t pix;
        logic   single_channel;
    } result_t;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_GRAY     = 2'd0;
    localparam mode_t MODE_NEGATIVE = 2'd1;
    localparam mode_t MODE_XRAY     = 2'd2;
    localparam mode_t MODE_WARM     = 2'd3;

    localparam chan_t CHAN_MAX = 8'd255;

    // X-ray curve floor(gray^1.5), saturated at full scale above gray 40.
    function automatic chan_t xray_lookup(input chan_t gray);
        chan_t val;
        case (gray)
            8'd0:    val = 8'd0;
            8'd1:    val = 8'd1;
            8'd2:    val = 8'd2;
            8'd3:    val = 8'd5;
            8'd4:    val = 8'd8;
            8'd5:    val = 8'd11;
            8'd6:    val = 8'd14;
            8'd7:    val = 8'd18;
            8'd8:    val = 8'd22;
            8'd9:    val = 8'd27;
            8'd10:   val = 8'd31;
            8'd11:   val = 8'd36;
            8'd12:   val = 8'd41;
            8'd13:   val = 8'd46;
            8'd14:   val = 8'd52;
            8'd15:   val = 8'd58;
            8'd16:   val = 8'd64;
            8'd17:   val = 8'd70;
            8'd18:   val = 8'd76;
            8'd19:   val = 8'd82;
            8'd20:   val = 8'd89;
            8'd21:   val = 8'd96;
            8'd22:   val = 8'd103;
            8'd23:   val = 8'd110;
            8'd24:   val = 8'd117;
            8'd25:   val = 8'd125;
            8'd26:   val = 8'd132;
            8'd27:   val = 8'd140;
            8'd28:   val = 8'd148;
            8'd29:   val = 8'd156;
            8'd30:   val = 8'd164;
            8'd31:   val = 8'd172;
            8'd32:   val = 8'd181;
            8'd33:   val = 8'd189;
            8'd34:   val = 8'd198;
            8'd35:   val = 8'd207;
            8'd36:   val = 8'd216;
            8'd37:   val = 8'd225;
            8'd38:   val = 8'd234;
            8'd39:   val = 8'd243;
            8'd40:   val = 8'd252;
            default: val = CHAN_MAX;
        endcase
        return val;
    endfunction

endpackage

/* rtl/pixel_color_filter_top.sv */
// Pixel color filter: each RGB pixel word is filtered by the mode in the two-bit
// register (0 grayscale, 1 negative, 2 x-ray, 3 warm sepia tone) and leaves as one
// result word; in the gray modes all three channels carry the same value and
// single_channel is set. A pixel is taken every clock while in_stall is low, and its
// result is valid on the output once it moves from the input register to the output
// register, the whole filter being one pass of logic between the two. Write the mode only
// while no pixel is in flight.
`include "pixel_color_filter_top_defines.svh"

module pixel_color_filter_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  pcf_pkg::chan_t in_red,
    input  pcf_pkg::chan_t in_green,
    input  pcf_pkg::chan_t in_blue,
    output logic           out_valid,
    input  logic           out_stall,
    output pcf_pkg::chan_t out_red,
    output pcf_pkg::chan_t out_green,
    output pcf_pkg::chan_t out_blue,
    output logic           single_channel,
    input  logic           cfg_we,
    input  pcf_pkg::mode_t cfg_wdata
);
    import pcf_pkg::*;

    mode_t   mode_reg;
    mode_t   mode_next;
    logic    s1_vld_reg;
    logic    s1_vld_next;
    pixel_t  s1_pix_reg;
    pixel_t  s1_pix_next;
    logic    out_vld_reg;
    logic    out_vld_next;
    result_t out_res_reg;
    result_t out_res_next;

    logic    s2_ready;
    logic    in_take;
    logic    s1_move;
    pixel_t  in_pix;
    result_t core_res;

    assign in_pix.red   = in_red;
    assign in_pix.green = in_green;
    assign in_pix.blue  = in_blue;

    assign s2_ready = !out_vld_reg || !out_stall;
    assign in_stall = s1_vld_reg && !s2_ready;
    assign in_take  = in_valid && !in_stall;
    assign s1_move  = s1_vld_reg && s2_ready;

    pcf_core u_core (
        .mode (mode_reg),
        .pix  (s1_pix_reg),
        .res  (core_res)
    );

    always_comb
    begin
        mode_next    = cfg_we ? cfg_wdata : mode_reg;
        s1_vld_next  = in_take || (s1_vld_reg && !s2_ready);
        s1_pix_next  = in_take ? in_pix : s1_pix_reg;
        out_vld_next = s2_ready ? s1_vld_reg : out_vld_reg;
        out_res_next = s1_move ? core_res : out_res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_GRAY;
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pix_reg  <= s1_pix_next;
        out_res_reg <= out_res_next;
    end

    assign out_valid      = out_vld_reg;
    assign out_red        = out_res_reg.pix.red;
    assign out_green      = out_res_reg.pix.green;
    assign out_blue       = out_res_reg.pix.blue;
    assign single_channel = out_res_reg.single_channel;

    // The input side only stalls when the input stage holds a word it cannot pass on.
    `PCF_ASSERT_ALWAYS(a_stall_needs_word, in_stall |-> s1_vld_reg)
    // An accepted word is always held in the input stage on the next cycle.
    `PCF_ASSERT(a_take_fills_stage, (in_valid && !in_stall) |=> s1_vld_reg)
    // A word leaving the input stage always shows up as a valid result.
    `PCF_ASSERT(a_move_gives_result, (s1_vld_reg && s2_ready) |=> out_valid)
    // A gray result carries the same value on all three channels.
    `PCF_ASSERT(a_gray_channels_match,
        (out_valid && single_channel) |-> (out_red == out_green && out_green == out_blue))

endmodule

/* rtl/pcf_luma.sv */
module pcf_luma (
    input  pcf_pkg::pixel_t pix,
    output pcf_pkg::chan_t  gray
);
    import pcf_pkg::*;

    // The per-mille weights 299, 587 and 114 are each folded with the reciprocal
    // ceil(2^28 / 1000), so one shift gives the exact floor of the sum over 1000.
    localparam int LUMA_SHIFT = 28;
    localparam int SUM_W      = 36;

    localparam logic [SUM_W-1:0] WEIGHT_RED   = 36'd80262364;
    localparam logic [SUM_W-1:0] WEIGHT_GREEN = 36'd157571932;
    localparam logic [SUM_W-1:0] WEIGHT_BLUE  = 36'd30601704;

    logic [SUM_W-1:0] prod_red;
    logic [SUM_W-1:0] prod_green;
    logic [SUM_W-1:0] prod_blue;
    logic [SUM_W-1:0] luma_sum;

    assign prod_red   = SUM_W'(pix.red) * WEIGHT_RED;
    assign prod_green = SUM_W'(pix.green) * WEIGHT_GREEN;
    assign prod_blue  = SUM_W'(pix.blue) * WEIGHT_BLUE;
    assign luma_sum   = prod_red + prod_green + prod_blue;
    assign gray       = luma_sum[LUMA_SHIFT +: CHAN_W];

endmodule

/* rtl/pcf_core.sv */
module pcf_core (
    input  pcf_pkg::mode_t   mode,
    input  pcf_pkg::pixel_t  pix,
    output pcf_pkg::result_t res
);
    import pcf_pkg::*;

    // A tenth is taken by multiplying with ceil(2^15 / 10) and shifting by 15,
    // which is exact for every value that 11c or 9c can reach.
    localparam int          TENTH_SHIFT = 15;
    localparam logic [15:0] WARM_UP_MUL = 16'd36047;
    localparam logic [14:0] WARM_DN_MUL = 15'd29493;
    localparam chan_t       WARM_OFFSET = 8'd10;

    function automatic chan_t warm_up(input chan_t c);
        logic [23:0] prod;
        logic [9:0]  lifted;
        prod   = 24'(c) * 24'(WARM_UP_MUL);
        lifted = 10'(prod[23:TENTH_SHIFT]) + 10'(WARM_OFFSET);
        return (lifted > 10'(CHAN_MAX)) ? CHAN_MAX : lifted[CHAN_W-1:0];
    endfunction

    function automatic chan_t warm_down(input chan_t c);
        logic [22:0] prod;
        chan_t       scaled;
        prod   = 23'(c) * 23'(WARM_DN_MUL);
        scaled = prod[22:TENTH_SHIFT];
        return (scaled > WARM_OFFSET) ? (scaled - WARM_OFFSET) : '0;
    endfunction

    chan_t gray;
    chan_t xray;

    pcf_luma u_luma (
        .pix  (pix),
        .gray (gray)
    );

    assign xray = xray_lookup(gray);

    always_comb
    begin
        case (mode)
            MODE_GRAY:
            begin
                res.pix.red        = gray;
                res.pix.green      = gray;
                res.pix.blue       = gray;
                res.single_channel = 1'b1;
            end
            MODE_NEGATIVE:
            begin
                res.pix.red        = ~pix.red;
                res.pix.green      = ~pix.green;
                res.pix.blue       = ~pix.blue;
                res.single_channel = 1'b0;
            end
            MODE_XRAY:
            begin
                res.pix.red        = xray;
                res.pix.green      = xray;
                res.pix.blue       = xray;
                res.single_channel = 1'b1;
            end
            default:
            begin
                res.pix.red        = warm_up(pix.red);
                res.pix.green      = warm_up(pix.green);
                res.pix.blue       = warm_down(pix.blue);
                res.single_channel = 1'b0;
            end
        endcase
    end

endmodule
